// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that an antecedent implies a consequent on the same edge.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/cau_pkg.sv
package cau_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QBITS         = 32;

    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SUB  = 3'd1;
    localparam logic [2:0] CMD_MUL  = 3'd2;
    localparam logic [2:0] CMD_DIV  = 3'd3;
    localparam logic [2:0] CMD_CONJ = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SMIN = 32'h8000_0000;

    localparam logic signed [64:0] LIM_HI = 65'sh0_0000_0000_7FFF_FFFF;
    localparam logic signed [64:0] LIM_LO = 65'sh1_FFFF_FFFF_8000_0000;

    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } t_sat;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] pre_re;
        logic [31:0] pre_im;
        logic        pre_sat;
        logic        den_zero;
    } t_meta;

    // One division lane: partial remainder, and the word that shifts out
    // dividend bits at the top while quotient bits enter at the bottom.
    typedef struct packed {
        logic        neg;
        logic        ovf;
        logic [63:0] rem;
        logic [31:0] rq;
    } t_lane;

    typedef struct packed {
        t_meta       meta;
        t_lane       re;
        t_lane       im;
        logic [63:0] den;
    } t_cell;

    function automatic t_sat sat65(input logic signed [64:0] v);
        t_sat r;
        r.sat = 1'b0;
        r.val = v[31:0];
        if (v > LIM_HI) begin
            r.sat = 1'b1;
            r.val = SMAX;
        end else if (v < LIM_LO) begin
            r.sat = 1'b1;
            r.val = SMIN;
        end
        return r;
    endfunction

    function automatic t_sat div_lane_out(input t_lane l);
        t_sat r;
        r.sat = 1'b0;
        r.val = l.neg ? 32'(-l.rq) : l.rq;
        if (!l.neg && (l.ovf || l.rq[31])) begin
            r.sat = 1'b1;
            r.val = SMAX;
        end else if (l.neg && (l.ovf || (l.rq[31] && (l.rq[30:0] != 31'd0)))) begin
            r.sat = 1'b1;
            r.val = SMIN;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/cau_div_cell.sv
module cau_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cau_pkg::t_cell i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output cau_pkg::t_cell o_data
);

    logic           r_valid;
    cau_pkg::t_cell r_data;
    cau_pkg::t_cell n_data;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    function automatic cau_pkg::t_lane step(input cau_pkg::t_lane l, input logic [63:0] den);
        cau_pkg::t_lane r;
        logic [64:0]    tmp;
        logic           ge;
        tmp   = {l.rem, l.rq[31]};
        ge    = (tmp >= {1'b0, den});
        r     = l;
        r.rem = ge ? 64'(tmp - {1'b0, den}) : tmp[63:0];
        r.rq  = {l.rq[30:0], ge};
        return r;
    endfunction

    always_comb begin
        n_data    = i_data;
        n_data.re = step(i_data.re, i_data.den);
        n_data.im = step(i_data.im, i_data.den);
    end

    assign o_ready = ~r_valid | i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// File: rtl/core/cau_front.sv
module cau_front #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    output logic               o_valid,
    input  logic               i_ready,
    output cau_pkg::t_cell     o_data
);

    localparam int SH = 32 - FRAC_BITS;

    logic rdy1, rdy2, rdy3;

    // stage 1: products and the simple operations
    logic               r1_valid;
    logic [2:0]         r1_cmd;
    logic signed [63:0] r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir, r1_q_rr, r1_q_ii;
    cau_pkg::t_sat      r1_pre_re, r1_pre_im;
    logic signed [64:0] s_re, s_im;

    always_comb begin
        case (i_command)
            cau_pkg::CMD_ADD: begin
                s_re = 65'(i_a_re) + 65'(i_b_re);
                s_im = 65'(i_a_im) + 65'(i_b_im);
            end
            cau_pkg::CMD_SUB: begin
                s_re = 65'(i_a_re) - 65'(i_b_re);
                s_im = 65'(i_a_im) - 65'(i_b_im);
            end
            cau_pkg::CMD_CONJ: begin
                s_re = 65'(i_a_re);
                s_im = -65'(i_a_im);
            end
            default: begin
                s_re = '0;
                s_im = '0;
            end
        endcase
    end

    // stage 2: exact sums of products
    logic               r2_valid;
    logic [2:0]         r2_cmd;
    cau_pkg::t_sat      r2_pre_re, r2_pre_im;
    logic signed [64:0] r2_m_re, r2_m_im, r2_d_re, r2_d_im;
    logic [63:0]        r2_den;

    // stage 3: scale, magnitudes and divider setup
    logic               r3_valid;
    cau_pkg::t_cell     r3_data;
    cau_pkg::t_cell     n3_data;
    cau_pkg::t_sat      mul_re, mul_im;
    logic               neg_re, neg_im;
    logic [63:0]        mag_re, mag_im, rem_re, rem_im;

    always_comb begin
        mul_re = cau_pkg::sat65(r2_m_re >>> FRAC_BITS);
        mul_im = cau_pkg::sat65(r2_m_im >>> FRAC_BITS);
        neg_re = r2_d_re[64];
        neg_im = r2_d_im[64];
        mag_re = neg_re ? 64'(-r2_d_re) : r2_d_re[63:0];
        mag_im = neg_im ? 64'(-r2_d_im) : r2_d_im[63:0];
        rem_re = mag_re >> SH;
        rem_im = mag_im >> SH;

        n3_data.meta.cmd      = r2_cmd;
        n3_data.meta.den_zero = (r2_den == 64'd0);
        if (r2_cmd == cau_pkg::CMD_MUL) begin
            n3_data.meta.pre_re  = mul_re.val;
            n3_data.meta.pre_im  = mul_im.val;
            n3_data.meta.pre_sat = mul_re.sat | mul_im.sat;
        end else begin
            n3_data.meta.pre_re  = r2_pre_re.val;
            n3_data.meta.pre_im  = r2_pre_im.val;
            n3_data.meta.pre_sat = r2_pre_re.sat | r2_pre_im.sat;
        end
        n3_data.den    = r2_den;
        n3_data.re.neg = neg_re;
        n3_data.re.ovf = (rem_re >= r2_den);
        n3_data.re.rem = rem_re;
        n3_data.re.rq  = 32'(mag_re << FRAC_BITS);
        n3_data.im.neg = neg_im;
        n3_data.im.ovf = (rem_im >= r2_den);
        n3_data.im.rem = rem_im;
        n3_data.im.rq  = 32'(mag_im << FRAC_BITS);
    end

    assign rdy3    = ~r3_valid | i_ready;
    assign rdy2    = ~r2_valid | rdy3;
    assign rdy1    = ~r1_valid | rdy2;
    assign o_ready = rdy1;
    assign o_valid = r3_valid;
    assign o_data  = r3_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (rdy1) r1_valid <= i_valid;
            if (rdy2) r2_valid <= r1_valid;
            if (rdy3) r3_valid <= r2_valid;
        end
        if (rdy1 && i_valid) begin
            r1_cmd    <= i_command;
            r1_p_rr   <= i_a_re * i_b_re;
            r1_p_ii   <= i_a_im * i_b_im;
            r1_p_ri   <= i_a_re * i_b_im;
            r1_p_ir   <= i_a_im * i_b_re;
            r1_q_rr   <= i_b_re * i_b_re;
            r1_q_ii   <= i_b_im * i_b_im;
            r1_pre_re <= cau_pkg::sat65(s_re);
            r1_pre_im <= cau_pkg::sat65(s_im);
        end
        if (rdy2 && r1_valid) begin
            r2_cmd    <= r1_cmd;
            r2_pre_re <= r1_pre_re;
            r2_pre_im <= r1_pre_im;
            r2_m_re   <= 65'(r1_p_rr) - 65'(r1_p_ii);
            r2_m_im   <= 65'(r1_p_ri) + 65'(r1_p_ir);
            r2_d_re   <= 65'(r1_p_rr) + 65'(r1_p_ii);
            r2_d_im   <= 65'(r1_p_ir) - 65'(r1_p_ri);
            r2_den    <= 64'(r1_q_rr) + 64'(r1_q_ii);
        end
        if (rdy3 && r2_valid) begin
            r3_data <= n3_data;
        end
    end

endmodule

// File: rtl/core/complex_arith_unit_top.sv
// Pipeline: 3 front stages, 32 divider cells, 1 output register; the same
// path for every command. Throughput: one transaction per cycle while the
// result side keeps i_out_ready high; each divider cell settles one quotient
// bit, so the 32-cell chain sets the latency, not the rate.
// Reset: synchronous active-low i_rst_n empties every stage; no state kept.
`include "assert_macros.svh"

module complex_arith_unit_top #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_res_re,
    output logic signed [31:0] o_res_im,
    output logic [1:0]         o_status
);

    logic           c_valid [cau_pkg::QBITS+1];
    logic           c_ready [cau_pkg::QBITS+1];
    cau_pkg::t_cell c_data  [cau_pkg::QBITS+1];

    cau_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_command (i_command),
        .i_a_re    (i_a_re),
        .i_a_im    (i_a_im),
        .i_b_re    (i_b_re),
        .i_b_im    (i_b_im),
        .o_valid   (c_valid[0]),
        .i_ready   (c_ready[0]),
        .o_data    (c_data[0])
    );

    for (genvar k = 0; k < cau_pkg::QBITS; k++) begin : g_cell
        cau_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_data  (c_data[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_data  (c_data[k+1])
        );
    end

    logic          r_o_valid;
    logic [31:0]   r_res_re, r_res_im;
    logic [1:0]    r_status;
    logic [31:0]   n_res_re, n_res_im;
    logic [1:0]    n_status;
    cau_pkg::t_sat q_re, q_im;
    cau_pkg::t_cell last;

    assign last = c_data[cau_pkg::QBITS];

    always_comb begin
        q_re = cau_pkg::div_lane_out(last.re);
        q_im = cau_pkg::div_lane_out(last.im);
        if (last.meta.cmd == cau_pkg::CMD_DIV) begin
            if (last.meta.den_zero) begin
                n_res_re = '0;
                n_res_im = '0;
                n_status = cau_pkg::ST_DIVZ;
            end else begin
                n_res_re = q_re.val;
                n_res_im = q_im.val;
                n_status = (q_re.sat | q_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
        end else begin
            n_res_re = last.meta.pre_re;
            n_res_im = last.meta.pre_im;
            n_status = last.meta.pre_sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
    end

    assign c_ready[cau_pkg::QBITS] = ~r_o_valid | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (c_ready[cau_pkg::QBITS]) begin
            r_o_valid <= c_valid[cau_pkg::QBITS];
        end
        if (c_ready[cau_pkg::QBITS] && c_valid[cau_pkg::QBITS]) begin
            r_res_re <= n_res_re;
            r_res_im <= n_res_im;
            r_status <= n_status;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_res_re    = r_res_re;
    assign o_res_im    = r_res_im;
    assign o_status    = r_status;

    `ASSERT_CLK(a_status_code, r_o_valid |-> (r_status != 2'd3), "status code out of range")
    `ASSERT_IMP(a_divz_zero, r_o_valid && (r_status == cau_pkg::ST_DIVZ), (r_res_re == 32'd0) && (r_res_im == 32'd0), "divide by zero result not cleared")
    `ASSERT_IMP(a_sat_clip, r_o_valid && (r_status == cau_pkg::ST_SAT), (r_res_re == cau_pkg::SMAX) || (r_res_re == cau_pkg::SMIN) || (r_res_im == cau_pkg::SMAX) || (r_res_im == cau_pkg::SMIN), "saturation flagged without clipped component")

endmodule

// File: bench/cau_checker.sv
`timescale 1ns / 1ps

module cau_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_res_re,
    input  logic signed [31:0] i_res_im,
    input  logic [1:0]         i_status,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int FRAC = cau_pkg::FRAC_BITS_DEF;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic [1:0]  status;
    } t_answer;

    t_answer answers_due[$];
    int      err_count = 0;

    // Clip a wide exact value to the signed 32-bit range.
    function automatic cau_pkg::t_sat clip32(input logic signed [99:0] v);
        cau_pkg::t_sat r;
        r.sat = 1'b0;
        r.val = v[31:0];
        if (v > 100'sd2147483647) begin
            r.sat = 1'b1;
            r.val = cau_pkg::SMAX;
        end else if (v < -100'sd2147483648) begin
            r.sat = 1'b1;
            r.val = cau_pkg::SMIN;
        end
        return r;
    endfunction

    function automatic t_answer complex_result(input logic [2:0] cmd,
                                               input logic signed [31:0] ar,
                                               input logic signed [31:0] ai,
                                               input logic signed [31:0] br,
                                               input logic signed [31:0] bi);
        logic signed [99:0] xr, xi, yr, yi, den;
        cau_pkg::t_sat      pr, pi;
        t_answer            a;
        xr = ar;
        xi = ai;
        yr = br;
        yi = bi;
        pr = '0;
        pi = '0;
        a.status = cau_pkg::ST_OK;
        case (cmd)
            cau_pkg::CMD_ADD: begin
                pr = clip32(xr + yr);
                pi = clip32(xi + yi);
            end
            cau_pkg::CMD_SUB: begin
                pr = clip32(xr - yr);
                pi = clip32(xi - yi);
            end
            cau_pkg::CMD_MUL: begin
                pr = clip32((xr * yr - xi * yi) >>> FRAC);
                pi = clip32((xr * yi + xi * yr) >>> FRAC);
            end
            cau_pkg::CMD_DIV: begin
                den = yr * yr + yi * yi;
                if (den == 0) begin
                    a.status = cau_pkg::ST_DIVZ;
                end else begin
                    // signed division truncates toward zero
                    pr = clip32(((xr * yr + xi * yi) <<< FRAC) / den);
                    pi = clip32(((xi * yr - xr * yi) <<< FRAC) / den);
                end
            end
            cau_pkg::CMD_CONJ: begin
                pr = clip32(xr);
                pi = clip32(-xi);
            end
            default: ;
        endcase
        a.re = pr.val;
        a.im = pi.val;
        if (a.status == cau_pkg::ST_OK && (pr.sat || pi.sat)) a.status = cau_pkg::ST_SAT;
        return a;
    endfunction

    assign o_pending = answers_due.size();
    assign o_errors  = err_count;

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && i_in_valid && i_in_ready)
            answers_due.push_back(complex_result(i_command, i_a_re, i_a_im,
                                                 i_b_re, i_b_im));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result re=%h im=%h status=%0d",
                         $time, i_res_re, i_res_im, i_status);
                err_count <= err_count + 1;
            end else begin
                want = answers_due.pop_front();
                if (want.re !== i_res_re || want.im !== i_res_im
                        || want.status !== i_status) begin
                    $display("%0t: mismatch expected re=%h im=%h status=%0d, %s%h %s%h %s%0d",
                             $time, want.re, want.im, want.status,
                             "got re=", i_res_re, "im=", i_res_im,
                             "status=", i_status);
                    err_count <= err_count + 1;
                end
            end
        end
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int N_RANDOM = 630;
    localparam int LATENCY  = 36;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [2:0]         i_command = cau_pkg::CMD_ADD;
    logic signed [31:0] i_a_re = '0;
    logic signed [31:0] i_a_im = '0;
    logic signed [31:0] i_b_re = '0;
    logic signed [31:0] i_b_im = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_res_re;
    logic signed [31:0] o_res_im;
    logic [1:0]         o_status;
    int                 errors;
    int                 pending;
    bit                 no_gaps = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    complex_arith_unit_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_command(i_command), .i_a_re(i_a_re), .i_a_im(i_a_im),
        .i_b_re(i_b_re), .i_b_im(i_b_im),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_res_re(o_res_re), .o_res_im(o_res_im), .o_status(o_status)
    );

    cau_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_command(i_command), .i_a_re(i_a_re), .i_a_im(i_a_im),
        .i_b_re(i_b_re), .i_b_im(i_b_im),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_res_re(o_res_re), .i_res_im(o_res_im), .i_status(o_status),
        .o_errors(errors), .o_pending(pending)
    );

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
            3: return 32'($urandom_range(0, 7)) - 32'd3;
            4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [2:0] cmd, input logic [31:0] ar,
                             input logic [31:0] ai, input logic [31:0] br,
                             input logic [31:0] bi);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command <= cmd;
        i_a_re <= ar;
        i_a_im <= ai;
        i_b_re <= br;
        i_b_im <= bi;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Result side: random stalls, one long hold-off to back the pipe up.
    initial begin
        int gap;
        int taken;
        taken = 0;
        @(posedge i_rst_n);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 19);
            if (taken == 40) gap = 300;
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
        end
    end

    initial begin
        logic [2:0] cmd;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(cau_pkg::CMD_ADD, cau_pkg::SMAX, cau_pkg::SMIN, 32'd1, 32'hFFFF_FFFF);
        send_item(cau_pkg::CMD_ADD, 32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000,
                  32'h0003_0000);
        send_item(cau_pkg::CMD_SUB, cau_pkg::SMIN, cau_pkg::SMAX, 32'd1, 32'hFFFF_FFFF);
        send_item(cau_pkg::CMD_SUB, 32'h0002_0000, 32'h0, 32'h0005_0000, 32'h0001_0000);
        send_item(cau_pkg::CMD_MUL, cau_pkg::SMIN, cau_pkg::SMIN, cau_pkg::SMIN,
                  cau_pkg::SMIN);
        send_item(cau_pkg::CMD_MUL, cau_pkg::SMIN, cau_pkg::SMIN, cau_pkg::SMIN,
                  cau_pkg::SMAX);
        send_item(cau_pkg::CMD_MUL, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000,
                  32'h0000_8000);
        send_item(cau_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0);
        send_item(cau_pkg::CMD_MUL, cau_pkg::SMAX, cau_pkg::SMAX, cau_pkg::SMAX,
                  cau_pkg::SMIN);
        send_item(cau_pkg::CMD_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
        send_item(cau_pkg::CMD_DIV, cau_pkg::SMAX, cau_pkg::SMIN, 32'h0, 32'h0);
        send_item(cau_pkg::CMD_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000,
                  32'hFFFF_0000);
        send_item(cau_pkg::CMD_DIV, cau_pkg::SMAX, cau_pkg::SMAX, 32'd1, 32'd0);
        send_item(cau_pkg::CMD_DIV, cau_pkg::SMIN, cau_pkg::SMIN, 32'd0, 32'hFFFF_FFFF);
        send_item(cau_pkg::CMD_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0003_0000, 32'h0);
        send_item(cau_pkg::CMD_DIV, cau_pkg::SMIN, cau_pkg::SMAX, cau_pkg::SMIN,
                  cau_pkg::SMIN);
        send_item(cau_pkg::CMD_CONJ, cau_pkg::SMIN, cau_pkg::SMIN, cau_pkg::SMAX,
                  cau_pkg::SMAX);
        send_item(cau_pkg::CMD_CONJ, cau_pkg::SMAX, cau_pkg::SMAX, 32'd0, 32'd0);
        send_item(cau_pkg::CMD_CONJ, 32'h1234_5678, 32'hFFFF_0001, 32'd5, 32'd7);
        send_item(3'd5, cau_pkg::SMAX, cau_pkg::SMIN, cau_pkg::SMAX, cau_pkg::SMIN);
        send_item(3'd6, 32'h1, 32'h2, 32'h3, 32'h4);
        send_item(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        for (int n = 0; n < N_RANDOM; n++) begin
            // alternate phases with and without gaps
            no_gaps = ((n / 80) % 3) == 1;
            cmd = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
            send_item(cmd, pick_word(), pick_word(),
                      ($urandom_range(0, 15) == 0) ? 32'd0 : pick_word(),
                      ($urandom_range(0, 15) == 0) ? 32'd0 : pick_word());
        end
        i_in_valid <= 1'b0;
        no_gaps = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_top: errors");
        $finish;
    end

endmodule
